FILE: design/rng_pkg.sv
`timescale 1ns / 1ps

package rng_pkg;

    localparam int COUNT_BITS_DEF = 32;

    localparam int HOLDOFF_W = 20;
    localparam int PULSE_W   = 10;
    localparam int TIMEOUT_W = 10;
    localparam int DIVISOR_W = 8;
    localparam int CM_W      = 10;
    localparam int DIST_W    = 11;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 20'd50000;
    localparam logic [PULSE_W-1:0]   PULSE_RST   = 10'd10;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd100;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 8'd58;
    localparam logic [CM_W-1:0]      MIN_CM_RST  = 10'd2;
    localparam logic [CM_W-1:0]      MAX_CM_RST  = 10'd400;

    localparam logic [DIST_W-1:0] DIST_SAT = 11'd1024;

    localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIVISOR = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CM  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CM  = 3'd5;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_PULSE = 2'd1,
        PH_ECHO  = 2'd2
    } phase_t;

    typedef enum logic {
        SEQ_ACCEPT = 1'b0,
        SEQ_DIVIDE = 1'b1
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/rng_div.sv
`timescale 1ns / 1ps

module rng_div #(
    parameter int COUNT_BITS = rng_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [COUNT_BITS-1:0]              dividend,
    input  logic [rng_pkg::DIVISOR_W-1:0]      divisor,
    output rng_pkg::div_stat_t                 stat,
    output logic [rng_pkg::DIST_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(COUNT_BITS);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]           dvd_reg, dvd_next;
    logic [rng_pkg::DIVISOR_W-1:0]   rem_reg, rem_next;
    logic [rng_pkg::DIST_W-1:0]      quo_reg, quo_next;
    logic                            ovf_reg, ovf_next;

    logic [rng_pkg::DIVISOR_W:0]     trial;
    logic [rng_pkg::DIVISOR_W:0]     diff;
    logic                            take;

    assign trial = {rem_reg, dvd_reg[COUNT_BITS-1]};
    assign take  = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(COUNT_BITS - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[COUNT_BITS-2:0], 1'b0};
            rem_next = take ? diff[rng_pkg::DIVISOR_W-1:0] : trial[rng_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[rng_pkg::DIST_W-2:0], take};
            ovf_next = ovf_reg | quo_reg[rng_pkg::DIST_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = (ovf_reg || (quo_reg > rng_pkg::DIST_SAT)) ? rng_pkg::DIST_SAT : quo_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != '0) |=> busy_reg)
        else $error("divider stopped early");
`endif

endmodule

FILE: design/ultrasonic_ranger_controller.sv
`timescale 1ns / 1ps
// A plain result is registered in the cycle after its input transaction; an item ending
// a measurement waits for the bit-serial divider, then loads the output register.
// Throughput: one item per cycle while the output is taken; none during a divide.
// Reset: rst_n asynchronous, active low; clears phase, counters, and the output valid,
// and loads the register defaults.

module ultrasonic_ranger_controller #(
    parameter int COUNT_BITS = rng_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] echo_level, [1] ms_tick
    input  logic [rng_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [0] trigger_level, [10:1] distance_cm, [11] measured, [12] timed_out
    output logic [rng_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rng_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rng_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [rng_pkg::HOLDOFF_W-1:0] holdoff_reg;
    logic [rng_pkg::PULSE_W-1:0]   pulse_reg;
    logic [rng_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [rng_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [rng_pkg::CM_W-1:0]      min_cm_reg;
    logic [rng_pkg::CM_W-1:0]      max_cm_reg;

    rng_pkg::seq_state_t           state_reg, state_next;
    rng_pkg::phase_t               phase_reg, phase_next;
    logic [COUNT_BITS-1:0]         elapsed_reg, elapsed_next;
    logic [rng_pkg::TIMEOUT_W-1:0] tl_reg, tl_next;
    logic                          echo_prev_reg, echo_prev_next;
    logic [rng_pkg::DIST_W-1:0]    last_dist_reg, last_dist_next;
    logic                          m_valid_reg, m_valid_next;
    logic [rng_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                          in_accept;
    logic                          echo;
    logic                          tick;
    logic                          rise;
    logic                          fall;
    logic [COUNT_BITS-1:0]         elapsed_inc;
    logic [rng_pkg::TIMEOUT_W-1:0] tl_dec;
    logic                          trig;
    logic                          tout;
    logic                          fall_hit;
    logic [rng_pkg::DIST_W-1:0]    win_src;
    logic [rng_pkg::CM_W-1:0]      dist_cm;

    rng_pkg::div_stat_t            div_stat;
    logic [rng_pkg::DIST_W-1:0]    div_quo;

    assign cfg_ready = 1'b1;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign echo      = s_axis_tdata[0];
    assign tick      = s_axis_tdata[1];
    assign rise      = !echo_prev_reg && echo;
    assign fall      = echo_prev_reg && !echo;
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign tl_dec    = (tick && tl_reg != '0) ? tl_reg - 1'b1 : tl_reg;

    // step the ranging phase on each input transaction
    always_comb
    begin
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        tl_next        = tl_reg;
        echo_prev_next = echo_prev_reg;
        trig           = 1'b0;
        tout           = 1'b0;
        fall_hit       = 1'b0;
        if (in_accept)
        begin
            echo_prev_next = echo;
            tl_next        = tl_dec;
            case (phase_reg)
                rng_pkg::PH_PULSE:
                begin
                    if (elapsed_reg >= COUNT_BITS'(pulse_reg))
                    begin
                        phase_next   = rng_pkg::PH_ECHO;
                        elapsed_next = '0;
                        tl_next      = timeout_reg;
                    end
                    else
                    begin
                        trig         = 1'b1;
                        elapsed_next = elapsed_inc;
                    end
                end
                rng_pkg::PH_ECHO:
                begin
                    if (fall)
                    begin
                        fall_hit     = 1'b1;
                        phase_next   = rng_pkg::PH_WAIT;
                        elapsed_next = '0;
                    end
                    else if (tl_dec == '0)
                    begin
                        tout         = 1'b1;
                        phase_next   = rng_pkg::PH_WAIT;
                        elapsed_next = '0;
                    end
                    else if (rise)
                    begin
                        elapsed_next = COUNT_BITS'(1);
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
                default:
                begin
                    phase_next = rng_pkg::PH_WAIT;
                    if (elapsed_reg >= COUNT_BITS'(holdoff_reg))
                    begin
                        phase_next   = rng_pkg::PH_PULSE;
                        elapsed_next = '0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
            endcase
        end
    end

    rng_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (fall_hit),
        .dividend (elapsed_reg),
        .divisor  (divisor_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign last_dist_next = div_stat.done ? div_quo : last_dist_reg;
    assign win_src = last_dist_next;
    assign dist_cm = (win_src >= {1'b0, min_cm_reg} && win_src <= {1'b0, max_cm_reg}) ?
                     win_src[rng_pkg::CM_W-1:0] : '0;

    // hold the result until taken; load it on a plain item or when the divide ends
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (in_accept && !fall_hit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, tout, 1'b0, dist_cm, trig};
        end
        else if (div_stat.done)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {3'b000, 1'b0, 1'b1, dist_cm, 1'b0};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rng_pkg::SEQ_ACCEPT:
            begin
                if (fall_hit)
                begin
                    state_next = rng_pkg::SEQ_DIVIDE;
                end
            end
            rng_pkg::SEQ_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = rng_pkg::SEQ_ACCEPT;
                end
            end
            default:
            begin
                state_next = rng_pkg::SEQ_ACCEPT;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            rng_pkg::SEQ_ACCEPT:
            begin
                s_axis_tready = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg <= rng_pkg::HOLDOFF_RST;
            pulse_reg   <= rng_pkg::PULSE_RST;
            timeout_reg <= rng_pkg::TIMEOUT_RST;
            divisor_reg <= rng_pkg::DIVISOR_RST;
            min_cm_reg  <= rng_pkg::MIN_CM_RST;
            max_cm_reg  <= rng_pkg::MAX_CM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rng_pkg::CFG_HOLDOFF: holdoff_reg <= cfg_data[rng_pkg::HOLDOFF_W-1:0];
                rng_pkg::CFG_PULSE:   pulse_reg   <= cfg_data[rng_pkg::PULSE_W-1:0];
                rng_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[rng_pkg::TIMEOUT_W-1:0];
                rng_pkg::CFG_DIVISOR: divisor_reg <= cfg_data[rng_pkg::DIVISOR_W-1:0];
                rng_pkg::CFG_MIN_CM:  min_cm_reg  <= cfg_data[rng_pkg::CM_W-1:0];
                rng_pkg::CFG_MAX_CM:  max_cm_reg  <= cfg_data[rng_pkg::CM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rng_pkg::SEQ_ACCEPT;
            phase_reg     <= rng_pkg::PH_WAIT;
            elapsed_reg   <= '0;
            tl_reg        <= '0;
            echo_prev_reg <= 1'b0;
            last_dist_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            tl_reg        <= tl_next;
            echo_prev_reg <= echo_prev_next;
            last_dist_reg <= last_dist_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rng_pkg::SEQ_DIVIDE) |-> !s_axis_tready)
        else $error("input taken during divide");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == rng_pkg::SEQ_DIVIDE))
        else $error("divide finished outside divide state");

    a_dist_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        last_dist_reg <= rng_pkg::DIST_SAT)
        else $error("stored distance above saturation");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_data_reg[11] && m_data_reg[12]))
        else $error("measured and timed_out both set");
`endif

endmodule
